>>> src/mtm_pkg.sv
// Shared types and constants for the memory-to-memory CPU core.
// Used by every module of the core; depends on nothing.
`default_nettype none
package mtm_pkg;

  localparam int WORD_BITS = 32;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  localparam logic [31:0] OPC_HALT  = 32'd0;
  localparam logic [31:0] OPC_ADD   = 32'd1;
  localparam logic [31:0] OPC_SUB   = 32'd2;
  localparam logic [31:0] OPC_MULT  = 32'd3;
  localparam logic [31:0] OPC_DIV   = 32'd4;
  localparam logic [31:0] OPC_COPY  = 32'd5;
  localparam logic [31:0] OPC_AND   = 32'd6;
  localparam logic [31:0] OPC_OR    = 32'd7;
  localparam logic [31:0] OPC_NOT   = 32'd8;
  localparam logic [31:0] OPC_SHL   = 32'd9;
  localparam logic [31:0] OPC_SAR   = 32'd10;
  localparam logic [31:0] OPC_LOAD  = 32'd11;
  localparam logic [31:0] OPC_STORE = 32'd12;
  localparam logic [31:0] OPC_BEQ   = 32'd13;
  localparam logic [31:0] OPC_BNE   = 32'd14;
  localparam logic [31:0] OPC_BLT   = 32'd15;
  localparam logic [31:0] OPC_CALL  = 32'd16;
  localparam logic [31:0] OPC_RET   = 32'd17;

  typedef struct packed {
    logic [1:0]         op;
    logic [13:0]        addr;
    logic signed [31:0] data;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               halted;
    logic               fault;
    logic [13:0]        pc;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

>>> src/mtm_mem.sv
// Single-port word memory with registered read data.
// Depends on mtm_pkg for the word width.
`default_nettype none
module mtm_mem #(
  parameter int ADDR_BITS = 14
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [31:0]          wdata,
  output logic [31:0]               rdata
);
  import mtm_pkg::*;

  logic [WORD_BITS-1:0] mem_r [0:(1<<ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

>>> src/mtm_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on mtm_pkg for the control struct.
`default_nettype none
module mtm_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output mtm_pkg::div_ctl_t      ctl,
  output logic [31:0]            q
);
  import mtm_pkg::*;

  logic        run_r, done_r, neg_r, zero_r;
  logic [5:0]  cnt_r;
  logic [31:0] quo_r, dvs_r;
  logic [32:0] rem_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r[31:0], quo_r[31]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= a[31] ? (~a + 32'd1) : a;
      dvs_r  <= b[31] ? (~b + 32'd1) : b;
      neg_r  <= a[31] ^ b[31];
      zero_r <= (b == 32'd0);
      rem_r  <= '0;
    end else if (run_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign ctl.start = start;
  assign ctl.done  = done_r;
  assign q = zero_r ? 32'd0 : (neg_r ? (~quo_r + 32'd1) : quo_r);
endmodule
`default_nettype wire

>>> src/memory_to_memory_cpu_core_top.sv
// Memory-to-memory CPU core: sequencer, operand registers and ALU.
// Depends on mtm_pkg, mtm_mem and mtm_div.
//
//  channel   ports                       direction  handshake
//  input     start, busy, in_word        in         start && !busy
//  result    out_valid, out_word         out        one-cycle strobe
//
// Write and idle items finish in the accepting cycle, reads go on through S_RDC.
// An instruction runs the accepting cycle, seven reads (issue and capture each) on the
// single memory port, one execute and one write-back, with a divider wait for divide.
// Reset is synchronous active low and clears the pc; memory is not cleared.
// Results are strobed in the cycle after the item finishes; the receiver cannot stall.
`default_nettype none
module memory_to_memory_cpu_core_top #(
  parameter int ADDR_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mtm_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output mtm_pkg::out_word_t      out_word
);
  import mtm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDC   = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_CAP   = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_DIVW  = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [2:0]           slot_r;
  logic [ADDR_BITS-1:0] pc_r, pc_nxt;
  logic [31:0]          opc_r, a1_r, a2_r, a3_r, x_r, y_r, z_r;
  logic [31:0]          res_r, res_nxt;
  logic [ADDR_BITS-1:0] wa_r, wa_nxt;
  logic                 wen_r, wen_nxt, halted_r, halted_nxt, fault_r, fault_nxt;
  logic                 out_valid_r;
  out_word_t            out_r;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr, pc_adv, slot_addr;
  logic [31:0]          mem_wdata, mem_rdata, div_q;
  logic [ADDR_BITS+13:0] in_addr_ext, pc_ext;
  logic                 div_start;
  div_ctl_t             div_ctl;

  assign in_addr_ext = {{ADDR_BITS{1'b0}}, in_word.addr};
  assign pc_ext      = {14'd0, pc_r};
  assign pc_adv      = pc_r + ADDR_BITS'(4);

  always_comb begin
    case (slot_r)
      3'd0, 3'd1, 3'd2, 3'd3: slot_addr = pc_r + ADDR_BITS'(slot_r);
      3'd4:    slot_addr = a2_r[ADDR_BITS-1:0];
      3'd5:    slot_addr = a3_r[ADDR_BITS-1:0];
      default: slot_addr = (opc_r == OPC_LOAD) ? (a2_r[ADDR_BITS-1:0] + y_r[ADDR_BITS-1:0])
                                               : a1_r[ADDR_BITS-1:0];
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = in_word.data;
    mem_addr  = in_addr_ext[ADDR_BITS-1:0];
    case (state_r)
      S_IDLE: begin
        mem_we = start && (in_word.op == OP_WRITE);
      end
      S_ISSUE: begin
        mem_addr = slot_addr;
      end
      S_WR: begin
        mem_we    = wen_r;
        mem_addr  = wa_r;
        mem_wdata = res_r;
      end
      default: begin
        mem_addr = in_addr_ext[ADDR_BITS-1:0];
      end
    endcase
  end

  mtm_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign div_start = (state_r == S_EXEC) && (opc_r == OPC_DIV);

  mtm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (x_r),
    .b     (y_r),
    .ctl   (div_ctl),
    .q     (div_q)
  );

  always_comb begin
    pc_nxt     = pc_adv;
    res_nxt    = 32'd0;
    wa_nxt     = a1_r[ADDR_BITS-1:0];
    wen_nxt    = 1'b1;
    halted_nxt = 1'b0;
    fault_nxt  = 1'b0;
    case (opc_r)
      OPC_HALT: begin
        wen_nxt = 1'b0; halted_nxt = 1'b1; pc_nxt = pc_r;
      end
      OPC_ADD:   res_nxt = x_r + y_r;
      OPC_SUB:   res_nxt = x_r - y_r;
      OPC_MULT:  res_nxt = x_r * y_r;
      OPC_DIV:   res_nxt = 32'd0;
      OPC_COPY:  res_nxt = x_r;
      OPC_AND:   res_nxt = x_r & y_r;
      OPC_OR:    res_nxt = x_r | y_r;
      OPC_NOT:   res_nxt = ~x_r;
      OPC_SHL:   res_nxt = x_r << y_r[4:0];
      OPC_SAR:   res_nxt = 32'($signed(x_r) >>> y_r[4:0]);
      OPC_LOAD:  res_nxt = z_r;
      OPC_STORE: begin
        res_nxt = z_r;
        wa_nxt  = a2_r[ADDR_BITS-1:0] + y_r[ADDR_BITS-1:0];
      end
      OPC_BEQ: begin
        wen_nxt = 1'b0;
        if (x_r == y_r) pc_nxt = a1_r[ADDR_BITS-1:0];
      end
      OPC_BNE: begin
        wen_nxt = 1'b0;
        if (x_r != y_r) pc_nxt = a1_r[ADDR_BITS-1:0];
      end
      OPC_BLT: begin
        wen_nxt = 1'b0;
        if ($signed(x_r) < $signed(y_r)) pc_nxt = a1_r[ADDR_BITS-1:0];
      end
      OPC_CALL: begin
        res_nxt = {{(32-ADDR_BITS){1'b0}}, pc_adv};
        wa_nxt  = a2_r[ADDR_BITS-1:0];
        pc_nxt  = a1_r[ADDR_BITS-1:0];
      end
      OPC_RET: begin
        wen_nxt = 1'b0;
        pc_nxt  = z_r[ADDR_BITS-1:0];
      end
      default: begin
        wen_nxt = 1'b0; halted_nxt = 1'b1; fault_nxt = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_word.op == OP_READ) state_nxt = S_RDC;
          else if (in_word.op == OP_EXEC) state_nxt = S_ISSUE;
        end
      end
      S_RDC:   state_nxt = S_IDLE;
      S_ISSUE: state_nxt = S_CAP;
      S_CAP:   state_nxt = (slot_r == 3'd6) ? S_EXEC : S_ISSUE;
      S_EXEC:  state_nxt = (opc_r == OPC_DIV) ? S_DIVW : S_WR;
      S_DIVW:  state_nxt = div_ctl.done ? S_WR : S_DIVW;
      S_WR:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == S_IDLE && start) begin
        slot_r <= '0;
        if (in_word.op != OP_READ && in_word.op != OP_EXEC) out_valid_r <= 1'b1;
      end
      if (state_r == S_CAP) slot_r <= slot_r + 3'd1;
      if (state_r == S_EXEC) pc_r <= pc_nxt;
      if (state_r == S_RDC || state_r == S_WR) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CAP) begin
      case (slot_r)
        3'd0:    opc_r <= mem_rdata;
        3'd1:    a1_r  <= mem_rdata;
        3'd2:    a2_r  <= mem_rdata;
        3'd3:    a3_r  <= mem_rdata;
        3'd4:    x_r   <= mem_rdata;
        3'd5:    y_r   <= mem_rdata;
        default: z_r   <= mem_rdata;
      endcase
    end
    if (state_r == S_EXEC) begin
      res_r    <= res_nxt;
      wa_r     <= wa_nxt;
      wen_r    <= wen_nxt;
      halted_r <= halted_nxt;
      fault_r  <= fault_nxt;
    end
    if (state_r == S_DIVW && div_ctl.done) res_r <= div_q;
    case (state_r)
      S_IDLE: begin
        out_r.read_data <= '0;
        out_r.halted    <= 1'b0;
        out_r.fault     <= 1'b0;
        out_r.pc        <= pc_ext[13:0];
      end
      S_RDC: begin
        out_r.read_data <= mem_rdata;
        out_r.halted    <= 1'b0;
        out_r.fault     <= 1'b0;
        out_r.pc        <= pc_ext[13:0];
      end
      S_WR: begin
        out_r.read_data <= '0;
        out_r.halted    <= halted_r;
        out_r.fault     <= fault_r;
        out_r.pc        <= pc_ext[13:0];
      end
      default: out_r <= out_r;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy)) else $error("item dropped");
  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.fault) |-> out_word.halted) else $error("fault without halt");
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.done |-> (state_r == S_DIVW)) else $error("divider done out of sequence");
  a_no_write_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE || state_r == S_CAP) |-> !mem_we) else $error("write during fetch");

endmodule
`default_nettype wire

>>> tb/sv/memory_to_memory_cpu_core_top_tb.sv
`timescale 1ns / 100ps
// Testbench for memory_to_memory_cpu_core_top: a queued command driver and a
// strobe monitor checked against an in-bench instruction-set predictor.
// Depends on mtm_pkg and the core RTL.
module memory_to_memory_cpu_core_top_tb;
  import mtm_pkg::*;

  localparam logic [31:0] AMASK      = 32'h3FFF;
  localparam int          IDLE_LIMIT = 4000;
  localparam logic [1:0]  OP_NOP     = 2'd3;
  localparam logic [31:0] OPC_BAD    = 32'd18;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  memory_to_memory_cpu_core_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word)
  );

  logic [31:0] mem_model [int];
  int          written_addrs[$];
  logic [13:0] pc_model = '0;
  in_word_t    pending_q[$];
  out_word_t   expect_q[$];
  out_word_t   exp_word;
  int          n_items = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  function automatic bit known(logic [31:0] a);
    return mem_model.exists(int'(a & AMASK));
  endfunction

  function automatic logic [31:0] mem_rd(logic [31:0] a);
    return known(a) ? mem_model[int'(a & AMASK)] : 32'd0;
  endfunction

  function automatic void mem_wr(logic [31:0] a, logic [31:0] v);
    int k;
    k = int'(a & AMASK);
    if (!mem_model.exists(k)) written_addrs.push_back(k);
    mem_model[k] = v;
  endfunction

  function automatic logic [31:0] quotient(logic [31:0] x, logic [31:0] y);
    if (y == 32'd0) return 32'd0;
    if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return x;
    return $signed(x) / $signed(y);
  endfunction

  function automatic out_word_t execute_item(in_word_t w);
    out_word_t   r;
    logic [31:0] s, opc, a1, a2, a3, x, y, nxt;
    r = '0;
    case (w.op)
      OP_WRITE: mem_wr(32'(w.addr), w.data);
      OP_READ:  r.read_data = mem_rd(32'(w.addr));
      OP_EXEC: begin
        s   = 32'(pc_model);
        opc = mem_rd(s);
        a1  = mem_rd(s + 1);
        a2  = mem_rd(s + 2);
        a3  = mem_rd(s + 3);
        nxt = (s + 4) & AMASK;
        x   = mem_rd(a2);
        y   = mem_rd(a3);
        case (opc)
          OPC_HALT: begin
            r.halted = 1'b1;
            nxt = s;
          end
          OPC_ADD:   mem_wr(a1, x + y);
          OPC_SUB:   mem_wr(a1, x - y);
          OPC_MULT:  mem_wr(a1, x * y);
          OPC_DIV:   mem_wr(a1, quotient(x, y));
          OPC_COPY:  mem_wr(a1, x);
          OPC_AND:   mem_wr(a1, x & y);
          OPC_OR:    mem_wr(a1, x | y);
          OPC_NOT:   mem_wr(a1, ~x);
          OPC_SHL:   mem_wr(a1, x << y[4:0]);
          OPC_SAR:   mem_wr(a1, $signed(x) >>> y[4:0]);
          OPC_LOAD:  mem_wr(a1, mem_rd(a2 + y));
          OPC_STORE: mem_wr(a2 + y, mem_rd(a1));
          OPC_BEQ:   if (x == y) nxt = a1 & AMASK;
          OPC_BNE:   if (x != y) nxt = a1 & AMASK;
          OPC_BLT:   if ($signed(x) < $signed(y)) nxt = a1 & AMASK;
          OPC_CALL: begin
            mem_wr(a2, nxt);
            nxt = a1 & AMASK;
          end
          OPC_RET:   nxt = mem_rd(a1) & AMASK;
          default: begin
            r.halted = 1'b1;
            r.fault  = 1'b1;
          end
        endcase
        pc_model = nxt[13:0];
      end
      default: ;
    endcase
    r.pc = pc_model;
    return r;
  endfunction

  // First word the next instruction would read that holds no value yet.
  function automatic int missing_addr();
    logic [31:0] s, opc, a1, a2, a3;
    s = 32'(pc_model);
    for (int i = 0; i < 4; i++) if (!known(s + i)) return int'((s + i) & AMASK);
    opc = mem_rd(s);
    a1  = mem_rd(s + 1);
    a2  = mem_rd(s + 2);
    a3  = mem_rd(s + 3);
    if (!known(a2)) return int'(a2 & AMASK);
    if (!known(a3)) return int'(a3 & AMASK);
    if (opc == OPC_LOAD && !known(a2 + mem_rd(a3))) return int'((a2 + mem_rd(a3)) & AMASK);
    if ((opc == OPC_STORE || opc == OPC_RET) && !known(a1)) return int'(a1 & AMASK);
    return -1;
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom % 6)
      0:       return $urandom_range(0, 40);
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_addr();
    case ($urandom % 8)
      0:       return $urandom;
      1:       return 32'(16380 + $urandom_range(0, 3));
      default: return 32'(256 + $urandom_range(0, 63));
    endcase
  endfunction

  task automatic queue_item(logic [1:0] op, logic [31:0] addr, logic [31:0] data);
    in_word_t w;
    w.op   = op;
    w.addr = addr[13:0];
    w.data = data;
    pending_q.push_back(w);
    expect_q.push_back(execute_item(w));
    n_items++;
  endtask

  task automatic fill_and_exec();
    int m;
    m = missing_addr();
    while (m >= 0) begin
      queue_item(OP_WRITE, 32'(m), rnd_val());
      m = missing_addr();
    end
    queue_item(OP_EXEC, $urandom, $urandom);
  endtask

  task automatic run_insn(logic [31:0] opc, logic [31:0] a1, logic [31:0] a2,
                          logic [31:0] a3, logic [31:0] x, logic [31:0] y);
    logic [31:0] p;
    p = 32'(pc_model);
    queue_item(OP_WRITE, p & AMASK, opc);
    queue_item(OP_WRITE, (p + 1) & AMASK, a1);
    queue_item(OP_WRITE, (p + 2) & AMASK, a2);
    queue_item(OP_WRITE, (p + 3) & AMASK, a3);
    queue_item(OP_WRITE, a2 & AMASK, x);
    queue_item(OP_WRITE, a3 & AMASK, y);
    fill_and_exec();
  endtask

  task automatic build_stimulus();
    int k;
    queue_item(OP_WRITE, 32'd16383, 32'h8000_0000);
    queue_item(OP_WRITE, 32'd1000, 32'h7FFF_FFFF);
    queue_item(OP_READ, 32'd16383, $urandom);
    queue_item(OP_READ, 32'd1000, 32'd0);
    queue_item(OP_NOP, 32'd16383, 32'hFFFF_FFFF);
    run_insn(OPC_ADD, 300, 301, 302, 32'h7FFF_FFFF, 1);
    run_insn(OPC_SUB, 300, 301, 302, 32'h8000_0000, 1);
    run_insn(OPC_MULT, 300, 301, 302, 32'h0001_FFFF, 32'h0001_0001);
    run_insn(OPC_DIV, 300, 301, 302, 32'h8000_0000, 32'hFFFF_FFFF);
    run_insn(OPC_DIV, 300, 301, 302, 5, 0);
    run_insn(OPC_DIV, 300, 301, 302, -7, 2);
    run_insn(OPC_COPY, 303, 301, 302, 32'hDEAD_BEEF, 0);
    run_insn(OPC_AND, 300, 301, 302, 32'hF0F0_FFFF, 32'h0FF0_F00F);
    run_insn(OPC_OR, 300, 301, 302, 32'hF0F0_0000, 32'h0FF0_000F);
    run_insn(OPC_NOT, 300, 301, 302, 32'h1234_5678, 0);
    run_insn(OPC_SHL, 300, 301, 302, 1, 33);
    run_insn(OPC_SAR, 300, 301, 302, 32'h8000_0000, 63);
    run_insn(OPC_LOAD, 300, 301, 302, 300, 3);
    run_insn(OPC_STORE, 303, 301, 302, 300, 32'hFFFF_FFFF);
    run_insn(OPC_BEQ, 16382, 301, 302, 9, 9);
    run_insn(OPC_BNE, 32'hFFFF_0020, 301, 302, 9, 8);
    run_insn(OPC_BLT, 60, 301, 302, -1, 0);
    run_insn(OPC_CALL, 100, 310, 302, 0, 0);
    run_insn(OPC_RET, 310, 301, 302, 0, 0);
    run_insn(OPC_HALT, 0, 301, 302, 0, 0);
    fill_and_exec();
    run_insn(OPC_BAD, 0, 301, 302, 0, 0);
    run_insn(32'hFFFF_FFFF, 0, 301, 302, 0, 0);
    while (n_items < 640) begin
      k = $urandom % 100;
      if (k < 10) queue_item(OP_WRITE, $urandom, rnd_val());
      else if (k < 20)
        queue_item(OP_READ, written_addrs[$urandom % written_addrs.size()], $urandom);
      else if (k < 23) queue_item(OP_NOP, $urandom, $urandom);
      else if (k < 40) fill_and_exec();
      else
        run_insn(($urandom % 20 == 0) ? $urandom_range(OPC_BAD, 32'hFFFF_FFFF)
                                      : $urandom_range(0, OPC_RET),
                 rnd_addr(), rnd_addr(), rnd_addr(), rnd_val(), rnd_val());
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_word <= pending_q.pop_front();
        start   <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        idle_cycles = 0;
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %p", out_word);
        end else begin
          exp_word = expect_q.pop_front();
          if (out_word.read_data !== exp_word.read_data ||
              out_word.halted !== exp_word.halted ||
              out_word.fault !== exp_word.fault || out_word.pc !== exp_word.pc) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected data=%h halted=%b fault=%b pc=%0d,",
                        " got data=%h halted=%b fault=%b pc=%0d"},
                       exp_word.read_data, exp_word.halted, exp_word.fault, exp_word.pc,
                       out_word.read_data, out_word.halted, out_word.fault, out_word.pc);
          end
        end
      end else if (start && !busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || start || expect_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
